>>> hdl/rdf_pkg.sv
package rdf_pkg;

    localparam int unsigned FRAME_BYTES_MAX = 1048576;
    localparam int unsigned SIZE_W = $clog2(FRAME_BYTES_MAX + 1);

    localparam logic [31:0] SIZE_MIN = 32'd22;
    localparam logic [15:0] VERSION_OK = 16'd1;
    localparam logic [15:0] KIND_OK = 16'd4;
    localparam logic [15:0] TAG_REMOTE = 16'd25;
    localparam logic [31:0] REMOTE_PLEN = 32'd5;

    // body offsets of the fixed header fields
    localparam logic [SIZE_W-1:0] POS_VERSION = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] POS_KIND = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] POS_TAG = SIZE_W'(5);
    localparam logic [SIZE_W-1:0] POS_CORR = SIZE_W'(13);
    localparam logic [SIZE_W-1:0] POS_PLEN = SIZE_W'(17);
    localparam logic [SIZE_W-1:0] POS_HDR_END = SIZE_W'(18);
    localparam logic [SIZE_W-1:0] POS_CODE_FIRST = SIZE_W'(19);
    localparam logic [SIZE_W-1:0] POS_CODE_LAST = SIZE_W'(22);

    localparam logic [1:0] CLS_HEADER = 2'd0;
    localparam logic [1:0] CLS_PAYLOAD = 2'd1;
    localparam logic [1:0] CLS_PROOF = 2'd2;
    localparam logic [1:0] CLS_DISCARD = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_REMOTE = 2'd3;

    typedef struct packed {
        logic signed [31:0] remote_code;
        logic [15:0]        frame_tag;
        logic [1:0]         status;
        logic               frame_end;
        logic [7:0]         data_byte;
        logic [1:0]         byte_class;
    } result_t;

endpackage

>>> hdl/rdf_in_stage.sv
module rdf_in_stage
    import rdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

    assign valid = valid_reg;
    assign in_byte = byte_reg;

endmodule

>>> hdl/rdf_parser.sv
module rdf_parser
    import rdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [7:0]  in_byte,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    output result_t     res
);

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_FAULT = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [63:0]       shift_reg, shift_next;
    logic [31:0]       plen_reg, plen_next;
    logic [15:0]       tag_reg, tag_next;
    logic              bad_reg, bad_next;
    logic [31:0]       code_reg, code_next;
    logic [63:0]       corr_reg;

    logic [63:0]       shifted;
    logic [31:0]       shifted32;
    logic [SIZE_W-1:0] room;
    logic [SIZE_W-1:0] plen_t;
    logic              plen_ok;
    logic [SIZE_W:0]   pos_x;
    logic [SIZE_W:0]   pay_lim;
    logic [SIZE_W:0]   proof_lim;

    assign shifted = {shift_reg[55:0], in_byte};
    assign shifted32 = {shift_reg[23:0], in_byte};
    assign room = size_reg - SIZE_W'(SIZE_MIN);
    assign plen_t = plen_reg[SIZE_W-1:0];
    assign plen_ok = plen_reg <= 32'(room);
    assign pos_x = {1'b0, pos_reg};
    assign pay_lim = {1'b0, plen_t} + (SIZE_W+1)'(POS_HDR_END);
    assign proof_lim = pay_lim + (SIZE_W+1)'(4);

    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        size_next = size_reg;
        shift_next = shift_reg;
        plen_next = plen_reg;
        tag_next = tag_reg;
        bad_next = bad_reg;
        code_next = code_reg;
        res = '0;
        if (step_en) begin
            case (phase_reg)
                PH_PREFIX: begin
                    res.byte_class = CLS_HEADER;
                    shift_next = {32'd0, shifted32};
                    pos_next = pos_reg + SIZE_W'(1);
                    if (pos_reg[1:0] == 2'd3) begin
                        pos_next = '0;
                        shift_next = '0;
                        if (shifted32 < SIZE_MIN || shifted32 > 32'(FRAME_BYTES_MAX)) begin
                            phase_next = PH_FAULT;
                            res.frame_end = 1'b1;
                            res.status = ST_LIMIT;
                        end else begin
                            size_next = shifted32[SIZE_W-1:0];
                            phase_next = PH_BODY;
                            bad_next = 1'b0;
                            tag_next = '0;
                            code_next = '0;
                            plen_next = '0;
                        end
                    end
                end
                PH_BODY: begin
                    if (pos_reg < POS_HDR_END) begin
                        res.byte_class = CLS_HEADER;
                        shift_next = shifted;
                        case (pos_reg)
                            POS_VERSION: begin
                                if (shifted[15:0] != VERSION_OK) begin
                                    bad_next = 1'b1;
                                end
                                shift_next = '0;
                            end
                            POS_KIND: begin
                                if (shifted[15:0] != KIND_OK) begin
                                    bad_next = 1'b1;
                                end
                                shift_next = '0;
                            end
                            POS_TAG: begin
                                tag_next = shifted[15:0];
                                shift_next = '0;
                            end
                            POS_CORR: begin
                                if (shifted != corr_reg) begin
                                    bad_next = 1'b1;
                                end
                                shift_next = '0;
                            end
                            POS_PLEN: begin
                                plen_next = shifted[31:0];
                                if (shifted[31:0] > 32'(room)) begin
                                    bad_next = 1'b1;
                                end
                                shift_next = '0;
                            end
                            default: begin
                            end
                        endcase
                    end else if (!plen_ok) begin
                        res.byte_class = CLS_DISCARD;
                    end else if (pos_x < pay_lim) begin
                        res.byte_class = CLS_PAYLOAD;
                        res.data_byte = in_byte;
                        if (pos_reg >= POS_CODE_FIRST && pos_reg <= POS_CODE_LAST) begin
                            code_next = {code_reg[23:0], in_byte};
                        end
                    end else if (pos_x < proof_lim) begin
                        res.byte_class = CLS_HEADER;
                        shift_next = {32'd0, shifted32};
                        if (pos_x == proof_lim - (SIZE_W+1)'(1)) begin
                            if (shifted32 != 32'(room - plen_t)) begin
                                bad_next = 1'b1;
                            end
                            shift_next = '0;
                        end
                    end else begin
                        res.byte_class = CLS_PROOF;
                        res.data_byte = in_byte;
                    end

                    if (pos_reg >= size_reg - SIZE_W'(1)) begin
                        res.frame_end = 1'b1;
                        res.frame_tag = tag_next;
                        if (bad_next) begin
                            res.status = ST_MALFORMED;
                        end else if (tag_next == TAG_REMOTE) begin
                            if (plen_next == REMOTE_PLEN && size_reg == SIZE_W'(27)
                                    && code_next[31]) begin
                                res.status = ST_REMOTE;
                                res.remote_code = code_next;
                            end else begin
                                res.status = ST_MALFORMED;
                            end
                        end
                        phase_next = PH_PREFIX;
                        pos_next = '0;
                        shift_next = '0;
                    end else begin
                        pos_next = pos_reg + SIZE_W'(1);
                    end
                end
                default: begin
                    res.byte_class = CLS_DISCARD;
                end
            endcase
        end
        if (cfg_wr_en && phase_reg == PH_FAULT) begin
            phase_next = PH_PREFIX;
            pos_next = '0;
            shift_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            pos_reg <= '0;
            size_reg <= '0;
            shift_reg <= '0;
            plen_reg <= '0;
            tag_reg <= '0;
            bad_reg <= 1'b0;
            code_reg <= '0;
            corr_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            size_reg <= size_next;
            shift_reg <= shift_next;
            plen_reg <= plen_next;
            tag_reg <= tag_next;
            bad_reg <= bad_next;
            code_reg <= code_next;
            if (cfg_wr_en) begin
                corr_reg <= cfg_wr_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fault_discards: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == PH_FAULT |-> res.byte_class == CLS_DISCARD && !res.frame_end)
        else $error("byte in fault phase not discarded");

    a_remote_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.status == ST_REMOTE |-> res.remote_code[31] && res.frame_end)
        else $error("remote status without negative code");

    a_limit_to_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.frame_end && res.status == ST_LIMIT && !cfg_wr_en
        |=> phase_reg == PH_FAULT)
        else $error("size error did not enter fault phase");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == PH_BODY && res.frame_end |=> phase_reg == PH_PREFIX
        && pos_reg == '0 && shift_reg == '0)
        else $error("frame end did not restart prefix");
`endif

endmodule

>>> hdl/rdf_out_stage.sv
module rdf_out_stage
    import rdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {6'd0, res_reg.remote_code, res_reg.frame_tag, res_reg.status,
                      res_reg.data_byte};
    assign m_tlast = res_reg.frame_end;
    assign m_tuser = res_reg.byte_class;

endmodule

>>> hdl/response_envelope_deframer_unit.sv
// Response envelope deframer.
// s_tdata carries the received stream one byte per request. Every byte gives
// one result request on the m_ side: m_tuser is the byte class (header, payload,
// proof, discarded), m_tdata echoes payload and proof bytes and, on the last
// byte of a frame (m_tlast), the status, tag and remote error code.
// A size error ends the frame at once and discards the stream until the next
// write on cfg_wr_en/cfg_wr_data, which also sets the expected correlation.
// After the input accept the byte sits in the input register, then the parse
// logic feeds the result register, which drives m_tvalid. One byte per cycle
// is sustained while the receiver does not stall; the parse state is updated
// once per byte as it enters the result register.
// When the receiver stalls the result register holds and the input register
// fills; s_tready drops only when both are occupied.
// Reset (aresetn low, synchronous) empties both registers, clears the parse
// state and sets the expected correlation to zero.
module response_envelope_deframer_unit
    import rdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // data_byte, status, frame_tag, remote_code, zero fill
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // byte_class
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       space;
    logic       step;
    result_t    res;

    assign step = in_valid && space;

    rdf_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (step),
        .valid    (in_valid),
        .in_byte  (in_byte)
    );

    rdf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step),
        .in_byte     (in_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    rdf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
